// ----- src/cpt_pkg.sv -----
// ----------------------------------------------------------------------------
// cpt_pkg: shared types, widths and arithmetic helpers
// Widths of every internal quantity of the closest point datapath, the region
// codes, and the small arithmetic functions that the pipeline stages use.
// ----------------------------------------------------------------------------
`default_nettype none

package cpt_pkg;

    localparam int COORD_W   = 24;
    localparam int QFRAC     = 16;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int DOT_W     = 2 * DIFF_W + 2;
    localparam int HALF_W    = DOT_W / 2;
    localparam int PP_W      = 2 * (HALF_W + 1);
    localparam int PROD_W    = 2 * DOT_W;
    localparam int VW        = PROD_W + 4;
    localparam int NUM_W     = VW + QFRAC;
    localparam int QBITS     = QFRAC + 1;
    localparam int T_W       = QBITS + 1;
    localparam int EP_W      = T_W + DIFF_W;
    localparam int ACC_W     = EP_W + 3;
    localparam int SH_W      = ACC_W - QFRAC;
    localparam int DIV_FIRST = 6;
    localparam int NST       = DIV_FIRST + QBITS + 2;

    typedef enum logic [2:0] {
        RGN_A,
        RGN_B,
        RGN_AB,
        RGN_C,
        RGN_AC,
        RGN_BC,
        RGN_INT,
        RGN_DEGEN
    } region_t;

    typedef logic [2:0][COORD_W-1:0] vec_c_t;
    typedef logic [2:0][DIFF_W-1:0]  vec_d_t;
    typedef logic signed [DOT_W-1:0] dot_t;
    typedef logic signed [VW-1:0]    wide_t;

    typedef struct packed {
        logic [PP_W-1:0] hh;
        logic [PP_W-1:0] hl;
        logic [PP_W-1:0] lh;
        logic [PP_W-1:0] ll;
    } pp_t;

    typedef struct packed {
        region_t          code;
        vec_c_t           base;
        vec_d_t           e1;
        vec_d_t           e2;
        logic             neg1;
        logic             neg2;
        logic [VW-1:0]    dmag;
        logic [NUM_W-1:0] r1;
        logic [NUM_W-1:0] r2;
        logic [QBITS-1:0] q1;
        logic [QBITS-1:0] q2;
    } div_t;

    function automatic vec_d_t sub3(input vec_c_t x, input vec_c_t y);
        vec_d_t r;
        for (int i = 0; i < 3; i++) begin
            r[i] = DIFF_W'($signed(x[i])) - DIFF_W'($signed(y[i]));
        end
        return r;
    endfunction

    function automatic dot_t dot3(input vec_d_t u, input vec_d_t v);
        dot_t                      acc;
        logic signed [2*DIFF_W-1:0] pr;
        acc = '0;
        for (int i = 0; i < 3; i++) begin
            pr  = $signed(u[i]) * $signed(v[i]);
            acc = acc + DOT_W'(pr);
        end
        return acc;
    endfunction

    // Splits a 52 by 52 product into four 54-bit partial products of its halves.
    function automatic pp_t pp_split(input dot_t x, input dot_t y);
        pp_t                     r;
        logic signed [HALF_W-1:0] xh;
        logic signed [HALF_W-1:0] yh;
        logic signed [HALF_W:0]   xl;
        logic signed [HALF_W:0]   yl;
        logic signed [PP_W-1:0]   t;
        xh   = x[DOT_W-1:HALF_W];
        yh   = y[DOT_W-1:HALF_W];
        xl   = {1'b0, x[HALF_W-1:0]};
        yl   = {1'b0, y[HALF_W-1:0]};
        t    = xh * yh;
        r.hh = t;
        t    = xh * yl;
        r.hl = t;
        t    = xl * yh;
        r.lh = t;
        t    = xl * yl;
        r.ll = t;
        return r;
    endfunction

    function automatic wide_t pp_join(input pp_t p);
        wide_t hh;
        wide_t hl;
        wide_t lh;
        wide_t ll;
        hh = wide_t'($signed(p.hh));
        hl = wide_t'($signed(p.hl));
        lh = wide_t'($signed(p.lh));
        ll = wide_t'($signed(p.ll));
        return (hh <<< (2 * HALF_W)) + ((hl + lh) <<< HALF_W) + ll;
    endfunction

    function automatic logic [VW-1:0] mag(input wide_t x);
        wide_t n;
        n = -x;
        return x[VW-1] ? n : x;
    endfunction

    // One restoring division step on both quotients at quotient bit pos.
    function automatic div_t div_step(input div_t s, input int pos);
        div_t             r;
        logic [NUM_W-1:0] dsh;
        r   = s;
        dsh = NUM_W'(s.dmag) << pos;
        if (s.r1 >= dsh) begin
            r.r1      = s.r1 - dsh;
            r.q1[pos] = 1'b1;
        end
        if (s.r2 >= dsh) begin
            r.r2      = s.r2 - dsh;
            r.q2[pos] = 1'b1;
        end
        return r;
    endfunction

    function automatic logic [COORD_W-1:0] sat(input logic signed [SH_W-1:0] v);
        logic [COORD_W-1:0] r;
        if ((&v[SH_W-1:COORD_W-1]) || !(|v[SH_W-1:COORD_W-1])) begin
            r = v[COORD_W-1:0];
        end
        else if (v[SH_W-1]) begin
            r = {1'b1, {(COORD_W-1){1'b0}}};
        end
        else begin
            r = {1'b0, {(COORD_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- src/cpt_query_if.sv -----
// ----------------------------------------------------------------------------
// cpt_query_if: query channel
// Carries one query point and three triangle vertices per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface cpt_query_if;
    logic                               valid;
    logic                               ready;
    logic signed [cpt_pkg::COORD_W-1:0] point_x;
    logic signed [cpt_pkg::COORD_W-1:0] point_y;
    logic signed [cpt_pkg::COORD_W-1:0] point_z;
    logic signed [cpt_pkg::COORD_W-1:0] vert_a_x;
    logic signed [cpt_pkg::COORD_W-1:0] vert_a_y;
    logic signed [cpt_pkg::COORD_W-1:0] vert_a_z;
    logic signed [cpt_pkg::COORD_W-1:0] vert_b_x;
    logic signed [cpt_pkg::COORD_W-1:0] vert_b_y;
    logic signed [cpt_pkg::COORD_W-1:0] vert_b_z;
    logic signed [cpt_pkg::COORD_W-1:0] vert_c_x;
    logic signed [cpt_pkg::COORD_W-1:0] vert_c_y;
    logic signed [cpt_pkg::COORD_W-1:0] vert_c_z;

    modport source (
        output valid, point_x, point_y, point_z, vert_a_x, vert_a_y, vert_a_z,
               vert_b_x, vert_b_y, vert_b_z, vert_c_x, vert_c_y, vert_c_z,
        input  ready
    );

    modport sink (
        input  valid, point_x, point_y, point_z, vert_a_x, vert_a_y, vert_a_z,
               vert_b_x, vert_b_y, vert_b_z, vert_c_x, vert_c_y, vert_c_z,
        output ready
    );
endinterface

`default_nettype wire

// ----- src/cpt_result_if.sv -----
// ----------------------------------------------------------------------------
// cpt_result_if: result channel
// Carries the closest point and its region code per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface cpt_result_if;
    logic                               valid;
    logic                               ready;
    logic signed [cpt_pkg::COORD_W-1:0] near_x;
    logic signed [cpt_pkg::COORD_W-1:0] near_y;
    logic signed [cpt_pkg::COORD_W-1:0] near_z;
    logic [2:0]                         region_code;

    modport source (
        output valid, near_x, near_y, near_z, region_code,
        input  ready
    );

    modport sink (
        input  valid, near_x, near_y, near_z, region_code,
        output ready
    );
endinterface

`default_nettype wire

// ----- src/closest_point_on_triangle.sv -----
// ----------------------------------------------------------------------------
// closest_point_on_triangle: closest point on a 3-D triangle
// Fixed-point pipeline that finds the nearest triangle point to a query point
// and the Voronoi region it lies in.
// ----------------------------------------------------------------------------
// The block takes one query transfer per clock unless a stalled output has
// filled every stage, and returns one result transfer per query, in order.
// It is built of 25 register stages: six arithmetic stages (differences,
// dot products, split 52-bit products, their joins, the barycentric sums,
// region selection), a 17-stage restoring divider that makes one quotient
// bit per stage for both barycentric parameters, and two stages that scale,
// round and saturate.
// Every stage holds its own valid bit, so a stalled output only blocks input
// once all stages are full.
`default_nettype none

module closest_point_on_triangle (
    input  logic          clk,
    input  logic          rst_n,
    cpt_query_if.sink     query,
    cpt_result_if.source  result
);

    logic [cpt_pkg::NST-1:0] v_reg;
    logic [cpt_pkg::NST-1:0] load;

    cpt_pkg::vec_c_t p_in;
    cpt_pkg::vec_c_t a_in;
    cpt_pkg::vec_c_t b_in;
    cpt_pkg::vec_c_t c_in;

    cpt_pkg::vec_c_t s1_a_reg, s1_b_reg, s1_c_reg;
    cpt_pkg::vec_d_t s1_ab_reg, s1_ac_reg, s1_bc_reg, s1_ap_reg, s1_bp_reg, s1_cp_reg;

    cpt_pkg::vec_c_t s2_a_reg, s2_b_reg, s2_c_reg;
    cpt_pkg::vec_d_t s2_ab_reg, s2_ac_reg, s2_bc_reg;
    cpt_pkg::dot_t   s2_d_reg [6];

    cpt_pkg::vec_c_t s3_a_reg, s3_b_reg, s3_c_reg;
    cpt_pkg::vec_d_t s3_ab_reg, s3_ac_reg, s3_bc_reg;
    cpt_pkg::dot_t   s3_d_reg [6];
    cpt_pkg::pp_t    s3_pp_reg [6];

    cpt_pkg::vec_c_t s4_a_reg, s4_b_reg, s4_c_reg;
    cpt_pkg::vec_d_t s4_ab_reg, s4_ac_reg, s4_bc_reg;
    cpt_pkg::dot_t   s4_d_reg [6];
    cpt_pkg::wide_t  s4_p_reg [6];

    cpt_pkg::vec_c_t s5_a_reg, s5_b_reg, s5_c_reg;
    cpt_pkg::vec_d_t s5_ab_reg, s5_ac_reg, s5_bc_reg;
    cpt_pkg::dot_t   s5_d_reg [6];
    cpt_pkg::wide_t  s5_va_reg, s5_vb_reg, s5_vc_reg, s5_den_reg;

    cpt_pkg::div_t   s6_reg;
    cpt_pkg::div_t   s6_next;
    cpt_pkg::div_t   dv_reg [cpt_pkg::QBITS];
    cpt_pkg::div_t   dv_next [cpt_pkg::QBITS];

    cpt_pkg::region_t                         m_code_reg;
    cpt_pkg::vec_c_t                          m_base_reg;
    logic [2:0][cpt_pkg::EP_W-1:0]            m_ep1_reg, m_ep2_reg;
    logic [2:0][cpt_pkg::EP_W-1:0]            m_ep1_next, m_ep2_next;

    cpt_pkg::region_t out_code_reg;
    cpt_pkg::vec_c_t  out_near_reg;
    cpt_pkg::vec_c_t  out_near_next;

    assign p_in = {query.point_z, query.point_y, query.point_x};
    assign a_in = {query.vert_a_z, query.vert_a_y, query.vert_a_x};
    assign b_in = {query.vert_b_z, query.vert_b_y, query.vert_b_x};
    assign c_in = {query.vert_c_z, query.vert_c_y, query.vert_c_x};

    always_comb
    begin
        load[cpt_pkg::NST-1] = !v_reg[cpt_pkg::NST-1] || result.ready;
        for (int k = cpt_pkg::NST - 2; k >= 0; k--) begin
            load[k] = !v_reg[k] || load[k+1];
        end
    end

    assign query.ready = load[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v_reg <= '0;
        end
        else begin
            if (load[0]) begin
                v_reg[0] <= query.valid;
            end
            for (int k = 1; k < cpt_pkg::NST; k++) begin
                if (load[k]) begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[0]) begin
            s1_a_reg  <= a_in;
            s1_b_reg  <= b_in;
            s1_c_reg  <= c_in;
            s1_ab_reg <= cpt_pkg::sub3(b_in, a_in);
            s1_ac_reg <= cpt_pkg::sub3(c_in, a_in);
            s1_bc_reg <= cpt_pkg::sub3(c_in, b_in);
            s1_ap_reg <= cpt_pkg::sub3(p_in, a_in);
            s1_bp_reg <= cpt_pkg::sub3(p_in, b_in);
            s1_cp_reg <= cpt_pkg::sub3(p_in, c_in);
        end
        if (load[1]) begin
            s2_a_reg    <= s1_a_reg;
            s2_b_reg    <= s1_b_reg;
            s2_c_reg    <= s1_c_reg;
            s2_ab_reg   <= s1_ab_reg;
            s2_ac_reg   <= s1_ac_reg;
            s2_bc_reg   <= s1_bc_reg;
            s2_d_reg[0] <= cpt_pkg::dot3(s1_ab_reg, s1_ap_reg);
            s2_d_reg[1] <= cpt_pkg::dot3(s1_ac_reg, s1_ap_reg);
            s2_d_reg[2] <= cpt_pkg::dot3(s1_ab_reg, s1_bp_reg);
            s2_d_reg[3] <= cpt_pkg::dot3(s1_ac_reg, s1_bp_reg);
            s2_d_reg[4] <= cpt_pkg::dot3(s1_ab_reg, s1_cp_reg);
            s2_d_reg[5] <= cpt_pkg::dot3(s1_ac_reg, s1_cp_reg);
        end
        if (load[2]) begin
            s3_a_reg     <= s2_a_reg;
            s3_b_reg     <= s2_b_reg;
            s3_c_reg     <= s2_c_reg;
            s3_ab_reg    <= s2_ab_reg;
            s3_ac_reg    <= s2_ac_reg;
            s3_bc_reg    <= s2_bc_reg;
            s3_d_reg     <= s2_d_reg;
            s3_pp_reg[0] <= cpt_pkg::pp_split(s2_d_reg[0], s2_d_reg[3]);
            s3_pp_reg[1] <= cpt_pkg::pp_split(s2_d_reg[2], s2_d_reg[1]);
            s3_pp_reg[2] <= cpt_pkg::pp_split(s2_d_reg[4], s2_d_reg[1]);
            s3_pp_reg[3] <= cpt_pkg::pp_split(s2_d_reg[0], s2_d_reg[5]);
            s3_pp_reg[4] <= cpt_pkg::pp_split(s2_d_reg[2], s2_d_reg[5]);
            s3_pp_reg[5] <= cpt_pkg::pp_split(s2_d_reg[4], s2_d_reg[3]);
        end
        if (load[3]) begin
            s4_a_reg  <= s3_a_reg;
            s4_b_reg  <= s3_b_reg;
            s4_c_reg  <= s3_c_reg;
            s4_ab_reg <= s3_ab_reg;
            s4_ac_reg <= s3_ac_reg;
            s4_bc_reg <= s3_bc_reg;
            s4_d_reg  <= s3_d_reg;
            for (int i = 0; i < 6; i++) begin
                s4_p_reg[i] <= cpt_pkg::pp_join(s3_pp_reg[i]);
            end
        end
        if (load[4]) begin
            s5_a_reg   <= s4_a_reg;
            s5_b_reg   <= s4_b_reg;
            s5_c_reg   <= s4_c_reg;
            s5_ab_reg  <= s4_ab_reg;
            s5_ac_reg  <= s4_ac_reg;
            s5_bc_reg  <= s4_bc_reg;
            s5_d_reg   <= s4_d_reg;
            s5_vc_reg  <= s4_p_reg[0] - s4_p_reg[1];
            s5_vb_reg  <= s4_p_reg[2] - s4_p_reg[3];
            s5_va_reg  <= s4_p_reg[4] - s4_p_reg[5];
            s5_den_reg <= (s4_p_reg[0] - s4_p_reg[1]) + (s4_p_reg[2] - s4_p_reg[3])
                        + (s4_p_reg[4] - s4_p_reg[5]);
        end
        if (load[5]) begin
            s6_reg <= s6_next;
        end
        for (int j = 0; j < cpt_pkg::QBITS; j++) begin
            if (load[cpt_pkg::DIV_FIRST + j]) begin
                dv_reg[j] <= dv_next[j];
            end
        end
        if (load[cpt_pkg::NST-2]) begin
            m_code_reg <= dv_reg[cpt_pkg::QBITS-1].code;
            m_base_reg <= dv_reg[cpt_pkg::QBITS-1].base;
            m_ep1_reg  <= m_ep1_next;
            m_ep2_reg  <= m_ep2_next;
        end
        if (load[cpt_pkg::NST-1]) begin
            out_code_reg <= m_code_reg;
            out_near_reg <= out_near_next;
        end
    end

    // Region selection and divider setup.
    always_comb
    begin
        cpt_pkg::dot_t              d1, d2, d3, d4, d5, d6;
        logic signed [cpt_pkg::DOT_W:0] d43, d56;
        cpt_pkg::wide_t             num1, num2, dd;
        d1   = s5_d_reg[0];
        d2   = s5_d_reg[1];
        d3   = s5_d_reg[2];
        d4   = s5_d_reg[3];
        d5   = s5_d_reg[4];
        d6   = s5_d_reg[5];
        d43  = $signed({d4[cpt_pkg::DOT_W-1], d4}) - $signed({d3[cpt_pkg::DOT_W-1], d3});
        d56  = $signed({d5[cpt_pkg::DOT_W-1], d5}) - $signed({d6[cpt_pkg::DOT_W-1], d6});
        num1 = s5_vb_reg;
        num2 = s5_vc_reg;
        dd   = s5_den_reg;
        s6_next      = '0;
        s6_next.code = cpt_pkg::RGN_INT;
        s6_next.base = s5_a_reg;
        s6_next.e1   = s5_ab_reg;
        s6_next.e2   = s5_ac_reg;
        if (d1 <= 0 && d2 <= 0) begin
            s6_next.code = cpt_pkg::RGN_A;
        end
        else if (d3 >= 0 && d43 <= 0) begin
            s6_next.code = cpt_pkg::RGN_B;
            s6_next.base = s5_b_reg;
        end
        else if (s5_vc_reg <= 0 && d1 >= 0 && d3 <= 0) begin
            s6_next.code = cpt_pkg::RGN_AB;
            num1 = cpt_pkg::wide_t'(d1);
            num2 = '0;
            dd   = cpt_pkg::wide_t'(d1) - cpt_pkg::wide_t'(d3);
        end
        else if (d6 >= 0 && d56 <= 0) begin
            s6_next.code = cpt_pkg::RGN_C;
            s6_next.base = s5_c_reg;
        end
        else if (s5_vb_reg <= 0 && d2 >= 0 && d6 <= 0) begin
            s6_next.code = cpt_pkg::RGN_AC;
            s6_next.e1   = s5_ac_reg;
            num1 = cpt_pkg::wide_t'(d2);
            num2 = '0;
            dd   = cpt_pkg::wide_t'(d2) - cpt_pkg::wide_t'(d6);
        end
        else if (s5_va_reg <= 0 && d43 >= 0 && d56 >= 0) begin
            s6_next.code = cpt_pkg::RGN_BC;
            s6_next.base = s5_b_reg;
            s6_next.e1   = s5_bc_reg;
            num1 = cpt_pkg::wide_t'(d43);
            num2 = '0;
            dd   = cpt_pkg::wide_t'(d43) + cpt_pkg::wide_t'(d56);
        end
        if (s6_next.code == cpt_pkg::RGN_A || s6_next.code == cpt_pkg::RGN_B
                || s6_next.code == cpt_pkg::RGN_C) begin
            num1 = '0;
            num2 = '0;
            dd   = cpt_pkg::wide_t'(1);
        end
        else if (dd == 0) begin
            s6_next.code = cpt_pkg::RGN_DEGEN;
            s6_next.base = s5_a_reg;
            num1 = '0;
            num2 = '0;
            dd   = cpt_pkg::wide_t'(1);
        end
        s6_next.dmag = cpt_pkg::mag(dd);
        s6_next.neg1 = num1[cpt_pkg::VW-1] ^ dd[cpt_pkg::VW-1];
        s6_next.neg2 = num2[cpt_pkg::VW-1] ^ dd[cpt_pkg::VW-1];
        s6_next.r1   = cpt_pkg::NUM_W'(cpt_pkg::mag(num1)) << cpt_pkg::QFRAC;
        s6_next.r2   = cpt_pkg::NUM_W'(cpt_pkg::mag(num2)) << cpt_pkg::QFRAC;
    end

    always_comb
    begin
        dv_next[0] = cpt_pkg::div_step(s6_reg, cpt_pkg::QBITS - 1);
        for (int j = 1; j < cpt_pkg::QBITS; j++) begin
            dv_next[j] = cpt_pkg::div_step(dv_reg[j-1], cpt_pkg::QBITS - 1 - j);
        end
    end

    always_comb
    begin
        logic signed [cpt_pkg::T_W-1:0]  t1, t2;
        logic signed [cpt_pkg::EP_W-1:0] pr;
        t1 = $signed({1'b0, dv_reg[cpt_pkg::QBITS-1].q1});
        t2 = $signed({1'b0, dv_reg[cpt_pkg::QBITS-1].q2});
        if (dv_reg[cpt_pkg::QBITS-1].neg1) begin
            t1 = -t1;
        end
        if (dv_reg[cpt_pkg::QBITS-1].neg2) begin
            t2 = -t2;
        end
        for (int i = 0; i < 3; i++) begin
            pr            = t1 * $signed(dv_reg[cpt_pkg::QBITS-1].e1[i]);
            m_ep1_next[i] = pr;
            pr            = t2 * $signed(dv_reg[cpt_pkg::QBITS-1].e2[i]);
            m_ep2_next[i] = pr;
        end
    end

    always_comb
    begin
        logic signed [cpt_pkg::ACC_W-1:0] acc;
        for (int i = 0; i < 3; i++) begin
            acc = (cpt_pkg::ACC_W'($signed(m_base_reg[i])) <<< cpt_pkg::QFRAC)
                + cpt_pkg::ACC_W'($signed(m_ep1_reg[i]))
                + cpt_pkg::ACC_W'($signed(m_ep2_reg[i]))
                + cpt_pkg::ACC_W'(1 <<< (cpt_pkg::QFRAC - 1));
            out_near_next[i] = cpt_pkg::sat(acc[cpt_pkg::ACC_W-1:cpt_pkg::QFRAC]);
        end
    end

    assign result.valid       = v_reg[cpt_pkg::NST-1];
    assign result.near_x      = out_near_reg[0];
    assign result.near_y      = out_near_reg[1];
    assign result.near_z      = out_near_reg[2];
    assign result.region_code = out_code_reg;

    a_ready_only_on_full_stall: assert property (
        @(posedge clk) disable iff (!rst_n)
        !query.ready |-> (result.valid && !result.ready)
    ) else $error("query stalled while the output was free");

    a_div_remainder_below_divisor: assert property (
        @(posedge clk) disable iff (!rst_n)
        v_reg[cpt_pkg::NST-3]
            |-> (dv_reg[cpt_pkg::QBITS-1].r1 < cpt_pkg::NUM_W'(dv_reg[cpt_pkg::QBITS-1].dmag))
             && (dv_reg[cpt_pkg::QBITS-1].r2 < cpt_pkg::NUM_W'(dv_reg[cpt_pkg::QBITS-1].dmag))
    ) else $error("divider quotient overflowed its width");

    a_vertex_has_zero_params: assert property (
        @(posedge clk) disable iff (!rst_n)
        (v_reg[cpt_pkg::NST-3]
            && (dv_reg[cpt_pkg::QBITS-1].code == cpt_pkg::RGN_A
             || dv_reg[cpt_pkg::QBITS-1].code == cpt_pkg::RGN_B
             || dv_reg[cpt_pkg::QBITS-1].code == cpt_pkg::RGN_C
             || dv_reg[cpt_pkg::QBITS-1].code == cpt_pkg::RGN_DEGEN))
            |-> (dv_reg[cpt_pkg::QBITS-1].q1 == '0) && (dv_reg[cpt_pkg::QBITS-1].q2 == '0)
    ) else $error("vertex or degenerate region carries a nonzero parameter");

endmodule

`default_nettype wire
